// ----- hw/rtl/vsrg_pkg.sv -----
// Shared constants and types for the V/F sine reference generator.
// No dependencies; used by vsrg_mul and vf_sine_reference_generator.
`timescale 1ns / 1ps
`default_nettype none

package vsrg_pkg;

    localparam int PHASE_BITS = 30;
    localparam int PH_SHIFT   = 32 - PHASE_BITS;
    localparam int MUL_W      = 32;
    localparam int CNT_W      = $clog2(MUL_W);

    localparam logic [31:0] STEP_GAIN   = 32'd5368709;
    localparam logic [31:0] TRIG_SCALE  = 32'd32440;
    localparam logic [11:0] PARK_LIMIT  = 12'd4055;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam logic [63:0] HALF_Q30    = 64'd536870912;
    localparam logic [33:0] ROUND_MAX   = 34'd32440;

    localparam logic [31:0] CQ1 = 32'd1686629713;
    localparam logic [31:0] CQ3 = 32'd693598668;
    localparam logic [31:0] CQ5 = 32'd85569306;
    localparam logic [31:0] CQ7 = 32'd5026995;
    localparam logic [31:0] CQ9 = 32'd172272;

    localparam logic [1:0] REG_RATED = 2'd0;
    localparam logic [1:0] REG_BOOST = 2'd1;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_BOOST  = 14'b00000000000010,
        S_LIN    = 14'b00000000000100,
        S_STEP   = 14'b00000000001000,
        S_SQ     = 14'b00000000010000,
        S_H7     = 14'b00000000100000,
        S_H5     = 14'b00000001000000,
        S_H3     = 14'b00000010000000,
        S_H1     = 14'b00000100000000,
        S_PX     = 14'b00001000000000,
        S_SC     = 14'b00010000000000,
        S_PARK_S = 14'b00100000000000,
        S_PARK_C = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } state_t;

    typedef struct packed {
        logic start;
        logic done;
        logic busy;
    } mul_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vsrg_mul.sv -----
// Bit-serial shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on vsrg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsrg_mul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [vsrg_pkg::MUL_W-1:0]    a,
    input  wire logic [vsrg_pkg::MUL_W-1:0]    b,
    output vsrg_pkg::mul_ctl_t                 ctl,
    output logic      [2*vsrg_pkg::MUL_W-1:0]  product
);

    logic [vsrg_pkg::MUL_W-1:0] a_reg;
    logic [vsrg_pkg::MUL_W-1:0] hi_reg;
    logic [vsrg_pkg::MUL_W-1:0] lo_reg;
    logic [vsrg_pkg::CNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [vsrg_pkg::MUL_W:0]   sum;

    // add the multiplicand under the current multiplier bit
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == vsrg_pkg::CNT_W'(vsrg_pkg::MUL_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[vsrg_pkg::MUL_W:1];
            lo_reg <= {sum[0], lo_reg[vsrg_pkg::MUL_W-1:1]};
        end
    end

    assign product   = {hi_reg, lo_reg};
    assign ctl.start = start;
    assign ctl.done  = done_reg;
    assign ctl.busy  = busy_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("multiply started while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == vsrg_pkg::CNT_W'(vsrg_pkg::MUL_W - 1)) |=> done_reg)
        else $error("last step gave no done");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/vf_sine_reference_generator.sv -----
// V/F sine reference generator: sequencer over one bit-serial multiplier.
// Each request runs 19 multiplies in turn on the shared serial multiplier, then the
// result is loaded into the output register.
// A new request is accepted only once the previous one has reached the output register.
// Next request is taken while a finished result waits in the output register.
// Reset (rst_n, async low): phase 0, rated_voltage 131072, boost_fraction 0.
// Depends on vsrg_pkg and vsrg_mul.
`timescale 1ns / 1ps
`default_nettype none

module vf_sine_reference_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // freq_command[18:0], freq_offset[36:19], zero pad
    input  wire logic        s_tuser,   // running
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [71:0] m_tdata,   // quad_voltage[12:0], sine_value[28:13],
                                        // cosine_value[44:29], alpha_voltage[57:45],
                                        // beta_voltage[70:58], zero pad
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [17:0] cfg_data
);

    vsrg_pkg::state_t state_reg, state_next;

    // configuration
    logic [17:0] rated_reg;
    logic [17:0] boost_frac_reg;

    // request payload
    logic signed [18:0] f_reg;
    logic signed [17:0] off_reg;
    logic               run_reg;

    // working values
    logic [vsrg_pkg::PHASE_BITS-1:0] phase_reg;
    logic [18:0] boost_reg;
    logic [12:0] quad_reg;
    logic [1:0]  quadrant_reg;
    logic [29:0] frac_reg;
    logic [30:0] x_reg;
    logic [30:0] s_reg;
    logic [31:0] p_reg;
    logic [31:0] r_reg;
    logic [15:0] sa_reg;
    logic signed [15:0] sn_reg;
    logic signed [15:0] cs_reg;
    logic [11:0] pmag_s_reg;
    logic        second_reg;
    logic        launched_reg;

    // output register
    logic        out_valid_reg;
    logic [71:0] out_data_reg;

    // multiplier
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic               mul_start;
    vsrg_pkg::mul_ctl_t mul_ctl;
    logic [63:0]        prod;

    // derived values
    logic [18:0] f_mag;
    logic signed [19:0] fsum;
    logic [19:0] fsum_mag;
    logic [20:0] lin_abs;
    logic [21:0] vf;
    logic [24:0] step_mag;
    logic [vsrg_pkg::PHASE_BITS-1:0] phase_new;
    logic [31:0] ph32;
    logic [63:0] rnd;
    logic [15:0] trig_val;
    logic signed [15:0] sn_val;
    logic signed [15:0] cs_val;
    logic [11:0] pmag;
    logic        is_mul;

    assign f_mag    = f_reg[18] ? 19'(-f_reg) : 19'(f_reg);
    assign fsum     = 20'(f_reg) + 20'(off_reg);
    assign fsum_mag = fsum[19] ? 20'(-fsum) : 20'(fsum);

    // floor shift of a signed product: negative side rounds magnitude up
    assign lin_abs  = f_reg[18] ? 21'((prod + 64'd131071) >> 17) : 21'(prod >> 17);
    assign vf       = 22'(lin_abs) + 22'(boost_reg);
    assign step_mag = fsum[19] ? 25'((prod + 64'd131071) >> 17) : 25'(prod >> 17);
    assign phase_new = fsum[19]
        ? vsrg_pkg::PHASE_BITS'(32'(phase_reg) - 32'(step_mag))
        : vsrg_pkg::PHASE_BITS'(32'(phase_reg) + 32'(step_mag));
    assign ph32 = 32'(phase_new) << vsrg_pkg::PH_SHIFT;

    // Q30 to Q15 scale, round half up, clamp
    assign rnd      = prod + vsrg_pkg::HALF_Q30;
    assign trig_val = (rnd[63:30] > vsrg_pkg::ROUND_MAX) ? 16'(vsrg_pkg::TRIG_SCALE)
                                                         : rnd[45:30];

    // quadrant fold, sa_reg holds sin part, trig_val the cos part
    always_comb
    begin
        case (quadrant_reg)
            2'd0:
            begin
                sn_val = $signed(sa_reg);
                cs_val = $signed(trig_val);
            end
            2'd1:
            begin
                sn_val = $signed(trig_val);
                cs_val = -$signed(sa_reg);
            end
            2'd2:
            begin
                sn_val = -$signed(sa_reg);
                cs_val = -$signed(trig_val);
            end
            default:
            begin
                sn_val = -$signed(trig_val);
                cs_val = $signed(sa_reg);
            end
        endcase
    end

    assign pmag = (prod[63:15] > 49'(vsrg_pkg::PARK_LIMIT)) ? vsrg_pkg::PARK_LIMIT
                                                            : prod[26:15];

    // operand select per step
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        is_mul = 1'b1;
        case (state_reg)
            vsrg_pkg::S_BOOST:
            begin
                mul_a = 32'(rated_reg);
                mul_b = 32'(boost_frac_reg);
            end
            vsrg_pkg::S_LIN:
            begin
                mul_a = 32'(rated_reg);
                mul_b = 32'(f_mag);
            end
            vsrg_pkg::S_STEP:
            begin
                mul_a = vsrg_pkg::STEP_GAIN;
                mul_b = 32'(fsum_mag);
            end
            vsrg_pkg::S_SQ:
            begin
                mul_a = 32'(x_reg);
                mul_b = 32'(x_reg);
            end
            vsrg_pkg::S_H7, vsrg_pkg::S_H5, vsrg_pkg::S_H3, vsrg_pkg::S_H1:
            begin
                mul_a = p_reg;
                mul_b = 32'(s_reg);
            end
            vsrg_pkg::S_PX:
            begin
                mul_a = p_reg;
                mul_b = 32'(x_reg);
            end
            vsrg_pkg::S_SC:
            begin
                mul_a = r_reg;
                mul_b = vsrg_pkg::TRIG_SCALE;
            end
            vsrg_pkg::S_PARK_S:
            begin
                mul_a = 32'(quad_reg);
                mul_b = sn_reg[15] ? 32'(-sn_reg) : 32'(sn_reg);
            end
            vsrg_pkg::S_PARK_C:
            begin
                mul_a = 32'(quad_reg);
                mul_b = cs_reg[15] ? 32'(-cs_reg) : 32'(cs_reg);
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    assign mul_start = is_mul && !launched_reg;

    vsrg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .ctl     (mul_ctl),
        .product (prod)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vsrg_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = vsrg_pkg::S_BOOST;
            end
            vsrg_pkg::S_BOOST:  if (mul_ctl.done) state_next = vsrg_pkg::S_LIN;
            vsrg_pkg::S_LIN:    if (mul_ctl.done) state_next = vsrg_pkg::S_STEP;
            vsrg_pkg::S_STEP:   if (mul_ctl.done) state_next = vsrg_pkg::S_SQ;
            vsrg_pkg::S_SQ:     if (mul_ctl.done) state_next = vsrg_pkg::S_H7;
            vsrg_pkg::S_H7:     if (mul_ctl.done) state_next = vsrg_pkg::S_H5;
            vsrg_pkg::S_H5:     if (mul_ctl.done) state_next = vsrg_pkg::S_H3;
            vsrg_pkg::S_H3:     if (mul_ctl.done) state_next = vsrg_pkg::S_H1;
            vsrg_pkg::S_H1:     if (mul_ctl.done) state_next = vsrg_pkg::S_PX;
            vsrg_pkg::S_PX:     if (mul_ctl.done) state_next = vsrg_pkg::S_SC;
            vsrg_pkg::S_SC:
            begin
                if (mul_ctl.done)
                    state_next = second_reg ? vsrg_pkg::S_PARK_S : vsrg_pkg::S_SQ;
            end
            vsrg_pkg::S_PARK_S: if (mul_ctl.done) state_next = vsrg_pkg::S_PARK_C;
            vsrg_pkg::S_PARK_C: if (mul_ctl.done) state_next = vsrg_pkg::S_DONE;
            vsrg_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = vsrg_pkg::S_IDLE;
            end
            default: state_next = vsrg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vsrg_pkg::S_IDLE;
            launched_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            rated_reg      <= 18'd131072;
            boost_frac_reg <= 18'd0;
            phase_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_start)
                launched_reg <= 1'b1;
            else if (mul_ctl.done)
                launched_reg <= 1'b0;

            if (cfg_valid)
            begin
                case (cfg_index)
                    vsrg_pkg::REG_RATED: rated_reg      <= cfg_data;
                    vsrg_pkg::REG_BOOST: boost_frac_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (state_reg == vsrg_pkg::S_STEP && mul_ctl.done)
                phase_reg <= phase_new;

            if (state_reg == vsrg_pkg::S_DONE && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath captures
    always_ff @(posedge clk)
    begin
        if (state_reg == vsrg_pkg::S_IDLE && s_tvalid)
        begin
            f_reg      <= $signed(s_tdata[18:0]);
            off_reg    <= $signed(s_tdata[36:19]);
            run_reg    <= s_tuser;
            second_reg <= 1'b0;
        end
        if (mul_ctl.done)
        begin
            case (state_reg)
                vsrg_pkg::S_BOOST: boost_reg <= prod[35:17];
                vsrg_pkg::S_LIN:
                begin
                    if (!run_reg)
                        quad_reg <= '0;
                    else if (vf >= 22'(rated_reg))
                        quad_reg <= rated_reg[17:5];
                    else
                        quad_reg <= vf[17:5];
                end
                vsrg_pkg::S_STEP:
                begin
                    quadrant_reg <= ph32[31:30];
                    frac_reg     <= ph32[29:0];
                    x_reg        <= {1'b0, ph32[29:0]};
                end
                vsrg_pkg::S_SQ:
                begin
                    s_reg <= prod[60:30];
                    p_reg <= vsrg_pkg::CQ9;
                end
                vsrg_pkg::S_H7: p_reg <= vsrg_pkg::CQ7 - prod[61:30];
                vsrg_pkg::S_H5: p_reg <= vsrg_pkg::CQ5 - prod[61:30];
                vsrg_pkg::S_H3: p_reg <= vsrg_pkg::CQ3 - prod[61:30];
                vsrg_pkg::S_H1: p_reg <= vsrg_pkg::CQ1 - prod[61:30];
                vsrg_pkg::S_PX: r_reg <= prod[61:30];
                vsrg_pkg::S_SC:
                begin
                    if (!second_reg)
                    begin
                        sa_reg     <= trig_val;
                        x_reg      <= vsrg_pkg::ONE_Q30 - {1'b0, frac_reg};
                        second_reg <= 1'b1;
                    end
                    else
                    begin
                        sn_reg <= sn_val;
                        cs_reg <= cs_val;
                    end
                end
                vsrg_pkg::S_PARK_S: pmag_s_reg <= pmag;
                default: ;
            endcase
        end
        // alpha is minus quad*sin; beta is quad*cos
        // loaded only once the previous result has left; the multiplier holds its product
        if (state_reg == vsrg_pkg::S_DONE && (!out_valid_reg || m_tready))
        begin
            out_data_reg[12:0]  <= quad_reg;
            out_data_reg[28:13] <= sn_reg;
            out_data_reg[44:29] <= cs_reg;
            out_data_reg[57:45] <= sn_reg[15] ? 13'(pmag_s_reg) : 13'(-13'(pmag_s_reg));
            out_data_reg[70:58] <= cs_reg[15] ? 13'(-13'(pmag)) : 13'(pmag);
            out_data_reg[71]    <= 1'b0;
        end
    end

    assign s_tready  = (state_reg == vsrg_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

endmodule

`default_nettype wire

// ----- bench/vf_sine_reference_generator_checker.sv -----
// Checker for the V/F sine reference generator: predicts each result from the
// accepted requests and register writes, and compares it field by field.
// Depends on vsrg_pkg (register indexes, phase width).
`timescale 1ns / 1ps

module vf_sine_reference_generator_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          result_count
);

    // last member sits in the lowest bits, matching m_tdata
    typedef struct packed {
        logic signed [12:0] beta;
        logic signed [12:0] alpha;
        logic signed [15:0] cosine;
        logic signed [15:0] sine;
        logic        [12:0] quad;
    } vf_result_t;

    logic [17:0] rated_q;
    logic [17:0] boost_q;
    logic [vsrg_pkg::PHASE_BITS-1:0] phase_q;
    vf_result_t expected_results[$];

    function automatic longint floor17(longint p);
        return p >>> 17;
    endfunction

    // 0.99*sin(pi/2*x), x in Q30
    function automatic longint quarter_wave(longint unsigned x);
        longint unsigned s, p, r;
        s = (x * x) >> 30;
        p = 64'd172272;
        p = 64'd5026995 - ((p * s) >> 30);
        p = 64'd85569306 - ((p * s) >> 30);
        p = 64'd693598668 - ((p * s) >> 30);
        p = 64'd1686629713 - ((p * s) >> 30);
        r = (p * x) >> 30;
        r = (r * 32440 + 64'd536870912) >> 30;
        if (r > 32440)
            r = 32440;
        return longint'(r);
    endfunction

    function automatic longint park(longint quad, longint trig);
        longint p, mag;
        p = quad * trig;
        mag = (p < 0 ? -p : p) >> 15;
        if (mag > 4055)
            mag = 4055;
        return p < 0 ? -mag : mag;
    endfunction

    function automatic vf_result_t predict_vf(logic [39:0] data, logic run);
        longint f, off, rated, boost, lin, vf, quad, step, sa, ca, sn, cs;
        longint unsigned ph32, frac;
        vf_result_t r;
        f = longint'($signed(data[18:0]));
        off = longint'($signed(data[36:19]));
        rated = longint'(rated_q);
        boost = (rated * longint'(boost_q)) >>> 17;
        lin = floor17(f * rated);
        if (lin < 0)
            lin = -lin;
        vf = lin + boost;
        if (vf >= rated)
            vf = rated;
        quad = run ? (vf >>> 5) : 0;
        step = floor17(64'sd5368709 * (f + off));
        phase_q = phase_q + vsrg_pkg::PHASE_BITS'(step);
        ph32 = (longint'(phase_q) << vsrg_pkg::PH_SHIFT) & 64'hFFFF_FFFF;
        frac = ph32 & 64'h3FFF_FFFF;
        sa = quarter_wave(frac);
        ca = quarter_wave(64'h4000_0000 - frac);
        case (ph32 >> 30)
            0: begin sn = sa;  cs = ca;  end
            1: begin sn = ca;  cs = -sa; end
            2: begin sn = -sa; cs = -ca; end
            default: begin sn = -ca; cs = sa; end
        endcase
        r.quad = 13'(quad);
        r.sine = 16'(sn);
        r.cosine = 16'(cs);
        r.alpha = 13'(-park(quad, sn));
        r.beta = 13'(park(quad, cs));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vf_result_t got, want;
        if (!rst_n)
        begin
            rated_q = 18'd131072;
            boost_q = '0;
            phase_q = '0;
            expected_results.delete();
            fail_count = 0;
            result_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == vsrg_pkg::REG_RATED)
                    rated_q = cfg_data;
                else if (cfg_index == vsrg_pkg::REG_BOOST)
                    boost_q = cfg_data;
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_vf(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                got = vf_result_t'(m_tdata[70:0]);
                result_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.quad !== want.quad)
                    begin
                        $error("quad_voltage exp %0d got %0d", want.quad, got.quad);
                        fail_count++;
                    end
                    if (got.sine !== want.sine)
                    begin
                        $error("sine_value exp %0d got %0d", want.sine, got.sine);
                        fail_count++;
                    end
                    if (got.cosine !== want.cosine)
                    begin
                        $error("cosine_value exp %0d got %0d", want.cosine, got.cosine);
                        fail_count++;
                    end
                    if (got.alpha !== want.alpha)
                    begin
                        $error("alpha_voltage exp %0d got %0d", want.alpha, got.alpha);
                        fail_count++;
                    end
                    if (got.beta !== want.beta)
                    begin
                        $error("beta_voltage exp %0d got %0d", want.beta, got.beta);
                        fail_count++;
                    end
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// ----- bench/vf_sine_reference_generator_tb.sv -----
// Testbench top for the V/F sine reference generator: drives requests and
// register writes, with random idling on both streams; checking is in the checker.
// Depends on vsrg_pkg, the generator RTL and vf_sine_reference_generator_checker.
`timescale 1ns / 1ps

module vf_sine_reference_generator_tb;

    localparam int RANDOM_ITEMS = 1080;
    // serial run time per request, plus sender gaps and receiver stalls, times margin
    localparam longint CYCLE_LIMIT = 64'd4_000_000;
    // register index past the end of the list
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // freq_command[18:0], freq_offset[36:19], zero pad
    logic        s_tuser;   // running
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // quad, sine, cosine, alpha, beta from bit 0 up
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [17:0] cfg_data;

    int  fail_count;
    int  pending;
    int  result_count;
    int  request_count;
    bit  no_idle;       // long stretch with no idling on either side
    longint cycles = 0;

    vf_sine_reference_generator dut (.*);

    vf_sine_reference_generator_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result side stalls about 27% of cycles unless in the no-idle window
    always @(posedge clk)
        m_tready <= no_idle || ($urandom_range(99) >= 27);

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("vf_sine_reference_generator_tb: done, errors");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [17:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one request; random gap first, then hold until accepted
    task automatic send_request(logic signed [18:0] freq, logic signed [17:0] offset,
                                logic run);
        while (!no_idle && $urandom_range(99) < 27)
            @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b0, offset, freq};
        s_tuser  <= run;
        do
            @(posedge clk);
        while (!s_tready);
        s_tvalid <= 1'b0;
        @(posedge clk);
        request_count++;
    endtask

    // wait for all results; the block is idle once nothing is outstanding
    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    task automatic random_request();
        logic signed [18:0] freq;
        logic signed [17:0] offset;
        case ($urandom_range(3))
            0: freq = 19'($urandom);
            1: freq = 19'($signed($urandom_range(8000)) - 4000);
            2: freq = $urandom_range(1) ? 19'sh3FFFF : 19'sh40000;
            default: freq = 19'($signed($urandom_range(262144)) - 131072);
        endcase
        offset = $urandom_range(3) == 0 ? 18'($urandom) : 18'($signed($urandom_range(64)) - 32);
        send_request(freq, offset, $urandom_range(99) < 85);
    endtask

    initial
    begin
        logic [17:0] rated_set[4];
        logic [17:0] boost_set[4];
        rated_set = '{18'h3FFFF, 18'd0, 18'd65536, 18'd131072};
        boost_set = '{18'd131072, 18'd0, 18'd13107, 18'h3FFFF};
        rst_n = 1'b0;
        no_idle = 1'b0;
        request_count = 0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= vsrg_pkg::REG_RATED;
        cfg_data <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, field extremes, stopped drive, reverse phase
        send_request(19'sd0, 18'sd0, 1'b1);
        send_request(19'sh3FFFF, 18'sh1FFFF, 1'b1);
        send_request(19'sh40000, 18'sh20000, 1'b1);
        send_request(19'sd131072, 18'sd0, 1'b0);
        send_request(-19'sd131072, -18'sd1, 1'b1);
        send_request(19'sd65536, 18'sd0, 1'b1);
        send_request(-19'sd1, 18'sd0, 1'b1);
        drain();
        write_reg(vsrg_pkg::REG_RATED, 18'h3FFFF);
        write_reg(vsrg_pkg::REG_BOOST, 18'd131072);
        send_request(19'sh3FFFF, 18'sd0, 1'b1);
        send_request(19'sd1, 18'sd0, 1'b1);
        send_request(19'sh40000, 18'sh1FFFF, 1'b0);
        // index past the list: the write must be ignored
        drain();
        write_reg(REG_UNUSED, 18'd77);
        send_request(19'sd1000, 18'sd5, 1'b1);
        drain();

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 4)
            begin
                write_reg(vsrg_pkg::REG_RATED, rated_set[ph]);
                write_reg(vsrg_pkg::REG_BOOST, boost_set[ph]);
            end
            else
            begin
                write_reg(vsrg_pkg::REG_RATED, 18'($urandom));
                write_reg(vsrg_pkg::REG_BOOST, 18'($urandom_range(131072)));
            end
            no_idle = (ph == 2);
            for (int i = 0; i < RANDOM_ITEMS / 8; i++)
                random_request();
            no_idle = 1'b0;
            drain();
        end

        drain();
        repeat (700)
            @(posedge clk);
        $display("Covered %0d requests, %0d results, eight register settings",
                 request_count, result_count);
        $display("with stopped drive, reverse phase and saturating voltage cases.");
        if (fail_count == 0 && pending == 0)
            $display("vf_sine_reference_generator_tb: done, clean");
        else
            $display("vf_sine_reference_generator_tb: done, errors");
        $finish;
    end

endmodule
